>>> src/b32sd_pkg.sv
`default_nettype none

package b32sd_pkg;

    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHR_TWO     = 8'h32;
    localparam logic [7:0] CHR_SEVEN   = 8'h37;
    localparam logic [7:0] DIGIT_BASE  = 8'd26;
    localparam logic [7:0] BYTE_MASK   = 8'hff;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_SYMBOL = 2'd1,
        STATUS_BAD_LENGTH = 2'd2,
        STATUS_TRAILING   = 2'd3
    } status_t;

    typedef struct packed {
        logic [6:0] residue_bits;
        logic [2:0] residue_count;
        logic [2:0] char_count;
        logic       symbol_error;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_text;
        status_t    status;
    } dec_result_t;

endpackage

`default_nettype wire

>>> src/base32_strict_decoder.sv
`default_nettype none

// Channel  Direction  Handshake           Beat contents
// input    in         in_valid/in_stall   symbol, last
// output   out        out_valid/out_stall data_byte, byte_valid, end_of_text, status
//
// One beat is accepted per clock and one result beat leaves per clock while the output is not stalled.
// A beat passes through an input register, then the symbol step into the result register.
// The residue and character count advance as a beat moves into the result register.
// A stalled output holds its result; the input register still takes one more beat if it is empty.
// Reset clears the decoder state and both valid flags.

module base32_strict_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] symbol,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic            end_of_text,
    output logic [1:0]      status
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             symbol_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   advance;
    b32sd_pkg::dec_state_t  state_reg;
    b32sd_pkg::dec_state_t  state_next;
    b32sd_pkg::dec_state_t  step_state;
    b32sd_pkg::dec_result_t result_reg;
    b32sd_pkg::dec_result_t step_result;

    b32sd_step u_step (
        .symbol     (symbol_reg),
        .last       (last_reg),
        .state      (state_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb
    begin
        advance  = in_valid_reg && !(out_valid_reg && out_stall);
        in_stall = in_valid_reg && !advance;

        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        state_next = advance ? step_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            symbol_reg <= symbol;
            last_reg   <= last;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = result_reg.data_byte;
    assign byte_valid  = result_reg.byte_valid;
    assign end_of_text = result_reg.end_of_text;
    assign status      = result_reg.status;

endmodule

`default_nettype wire

>>> src/b32sd_step.sv
`default_nettype none

module b32sd_step (
    input  wire logic [7:0]               symbol,
    input  wire logic                     last,
    input  wire b32sd_pkg::dec_state_t    state,
    output b32sd_pkg::dec_state_t         state_next,
    output b32sd_pkg::dec_result_t        result
);

    always_comb
    begin
        logic        is_letter;
        logic        is_digit;
        logic [7:0]  diff;
        logic [4:0]  value;
        logic [11:0] acc;
        logic [3:0]  cnt;
        logic [6:0]  keep_mask;
        logic [11:0] shifted;
        logic [2:0]  tail;

        is_letter = (symbol >= b32sd_pkg::CHR_LOWER_A) && (symbol <= b32sd_pkg::CHR_LOWER_Z);
        is_digit  = (symbol >= b32sd_pkg::CHR_TWO) && (symbol <= b32sd_pkg::CHR_SEVEN);
        if (is_letter)
        begin
            diff = symbol - b32sd_pkg::CHR_LOWER_A;
        end
        else
        begin
            diff = symbol - b32sd_pkg::CHR_TWO + b32sd_pkg::DIGIT_BASE;
        end
        value = diff[4:0];

        acc       = {state.residue_bits, value};
        cnt       = {1'b0, state.residue_count} + 4'd5;
        shifted   = 12'd0;
        keep_mask = 7'd0;

        state_next         = state;
        result.data_byte   = 8'd0;
        result.byte_valid  = 1'b0;
        result.end_of_text = last;
        result.status      = b32sd_pkg::STATUS_OK;

        if (!state.symbol_error)
        begin
            if (!(is_letter || is_digit))
            begin
                state_next.symbol_error = 1'b1;
            end
            else
            begin
                if (cnt >= 4'd8)
                begin
                    cnt               = cnt - 4'd8;
                    shifted           = acc >> cnt;
                    result.data_byte  = shifted[7:0] & b32sd_pkg::BYTE_MASK;
                    result.byte_valid = 1'b1;
                end
                keep_mask                = 7'h7f >> (3'd7 - cnt[2:0]);
                state_next.residue_count = cnt[2:0];
                state_next.residue_bits  = acc[6:0] & keep_mask;
            end
        end
        state_next.char_count = state.char_count + 3'd1;

        tail = state_next.char_count;
        if (last)
        begin
            if (tail == 3'd1 || tail == 3'd3 || tail == 3'd6)
            begin
                result.status = b32sd_pkg::STATUS_BAD_LENGTH;
            end
            else if (state_next.symbol_error)
            begin
                result.status = b32sd_pkg::STATUS_BAD_SYMBOL;
            end
            else if (state_next.residue_bits != 7'd0)
            begin
                result.status = b32sd_pkg::STATUS_TRAILING;
            end
            else
            begin
                result.status = b32sd_pkg::STATUS_OK;
            end
            state_next = '0;
        end
    end

endmodule

`default_nettype wire

>>> src/b32sd_checker.sv
`default_nettype none

module b32sd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] data_byte,
    input wire logic       byte_valid,
    input wire logic       end_of_text,
    input wire logic [1:0] status
);

    // The input side only backs up when a result is held at the output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output was free");

    a_status_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_text) |-> (status == 2'(b32sd_pkg::STATUS_OK)))
        else $error("status reported before the end of text");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (data_byte == 8'd0))
        else $error("data byte nonzero without a completed byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data_byte)
            && $stable(byte_valid) && $stable(end_of_text) && $stable(status)))
        else $error("stalled result beat changed");

endmodule

bind base32_strict_decoder b32sd_checker u_b32sd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .end_of_text (end_of_text),
    .status      (status)
);

`default_nettype wire

>>> verif/base32_strict_decoder_tb.sv
`default_nettype none

module base32_strict_decoder_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    class decode_scoreboard;
        b32sd_pkg::dec_result_t expected_beats[$];
        logic [6:0]  rem_bits;
        logic [2:0]  rem_count;
        logic [2:0]  chars_mod8;
        logic        saw_bad_char;
        int          errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            rem_bits = '0;
            rem_count = '0;
            chars_mod8 = '0;
            saw_bad_char = 1'b0;
        endfunction

        function void take_symbol(logic [7:0] ch, logic lst);
            b32sd_pkg::dec_result_t exp_beat;
            logic [4:0]  val;
            logic        is_b32;
            logic [11:0] acc;
            logic [3:0]  cnt;
            exp_beat = '0;
            exp_beat.status = b32sd_pkg::STATUS_OK;
            if (!saw_bad_char)
            begin
                is_b32 = 1'b1;
                val = '0;
                if (ch >= b32sd_pkg::CHR_LOWER_A && ch <= b32sd_pkg::CHR_LOWER_Z)
                    val = 5'(ch - b32sd_pkg::CHR_LOWER_A);
                else if (ch >= b32sd_pkg::CHR_TWO && ch <= b32sd_pkg::CHR_SEVEN)
                    val = 5'(ch - b32sd_pkg::CHR_TWO + b32sd_pkg::DIGIT_BASE);
                else
                    is_b32 = 1'b0;
                if (!is_b32)
                    saw_bad_char = 1'b1;
                else
                begin
                    acc = {rem_bits, val};
                    cnt = {1'b0, rem_count} + 4'd5;
                    if (cnt >= 4'd8)
                    begin
                        cnt = cnt - 4'd8;
                        exp_beat.data_byte = 8'((acc >> cnt) & 12'(b32sd_pkg::BYTE_MASK));
                        exp_beat.byte_valid = 1'b1;
                    end
                    rem_count = cnt[2:0];
                    rem_bits = 7'(acc & ((12'd1 << rem_count) - 12'd1));
                end
            end
            chars_mod8 = chars_mod8 + 3'd1;
            if (lst)
            begin
                exp_beat.end_of_text = 1'b1;
                if (chars_mod8 == 3'd1 || chars_mod8 == 3'd3 || chars_mod8 == 3'd6)
                    exp_beat.status = b32sd_pkg::STATUS_BAD_LENGTH;
                else if (saw_bad_char)
                    exp_beat.status = b32sd_pkg::STATUS_BAD_SYMBOL;
                else if (rem_bits != '0)
                    exp_beat.status = b32sd_pkg::STATUS_TRAILING;
                else
                    exp_beat.status = b32sd_pkg::STATUS_OK;
                clear_text();
            end
            expected_beats.push_back(exp_beat);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [7:0] db, logic bv, logic eot, logic [1:0] st);
            b32sd_pkg::dec_result_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                report("result beat with no decoded beat pending");
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (bv !== exp_beat.byte_valid)
                report($sformatf("byte_valid %b, expected %b", bv, exp_beat.byte_valid));
            if (db !== exp_beat.data_byte)
                report($sformatf("data_byte %h, expected %h", db, exp_beat.data_byte));
            if (eot !== exp_beat.end_of_text)
                report($sformatf("end_of_text %b, expected %b", eot, exp_beat.end_of_text));
            if (st !== exp_beat.status)
                report($sformatf("status %0d, expected %0d", st, exp_beat.status));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] symbol = '0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic [1:0] status;

    int send_idle_pct = 32;
    int recv_stall_pct = 66;
    int beats_sent = 0;
    int cycles = 0;

    decode_scoreboard sb = new();

    base32_strict_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .symbol      (symbol),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .end_of_text (end_of_text),
        .status      (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(data_byte, byte_valid, end_of_text, status);
    end

    function automatic logic [7:0] b32_char(logic [4:0] v);
        if (v < 5'd26)
            return b32sd_pkg::CHR_LOWER_A + 8'(v);
        return b32sd_pkg::CHR_TWO + 8'(v) - b32sd_pkg::DIGIT_BASE;
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol <= ch;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_symbol(ch, lst);
        beats_sent++;
    endtask

    task automatic send_random_text();
        int         len;
        int         tail_bits;
        bit         well_formed;
        bit         inject_bad;
        logic [4:0] v;
        logic [7:0] ch;
        well_formed = ($urandom_range(99) < 80);
        inject_bad = ($urandom_range(99) < 15);
        if (well_formed)
        begin
            case ($urandom_range(4))
                0: len = 2;
                1: len = 4;
                2: len = 5;
                3: len = 7;
                default: len = 8;
            endcase
            len += 8 * $urandom_range(2);
        end
        else
            len = $urandom_range(12, 1);
        tail_bits = (5 * len) % 8;
        for (int i = 0; i < len; i++)
        begin
            v = 5'($urandom_range(31));
            if (well_formed && i == len - 1 && $urandom_range(1) == 1)
                v = v & ~5'((1 << tail_bits) - 1);
            ch = b32_char(v);
            if ((well_formed && inject_bad && $urandom_range(len - 1) == 0)
                || (!well_formed && $urandom_range(1) == 1))
            begin
                ch = 8'($urandom_range(255));
                while ((ch >= b32sd_pkg::CHR_LOWER_A && ch <= b32sd_pkg::CHR_LOWER_Z)
                       || (ch >= b32sd_pkg::CHR_TWO && ch <= b32sd_pkg::CHR_SEVEN))
                    ch = 8'($urandom_range(255));
            end
            send_beat(ch, i == len - 1);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat("a", 1'b1);
        send_beat("z", 1'b0);
        send_beat("7", 1'b1);
        send_beat("2", 1'b0);
        send_beat("a", 1'b1);
        send_beat("m", 1'b0);
        send_beat(8'h41, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat("a", 1'b0);
        send_beat("a", 1'b1);
        send_beat("a", 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h60, 1'b0);
        send_beat(8'h7b, 1'b1);
        send_beat("1", 1'b0);
        send_beat("8", 1'b0);
        send_beat("a", 1'b0);
        send_beat("z", 1'b0);
        send_beat("7", 1'b0);
        send_beat("2", 1'b1);
        send_beat("7", 1'b0);
        send_beat("7", 1'b0);
        send_beat("7", 1'b0);
        send_beat("7", 1'b1);

        while (beats_sent < 600)
            send_random_text();
        send_idle_pct = 66;
        recv_stall_pct = 32;
        while (beats_sent < 1200)
            send_random_text();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (beats_sent < 1750)
            send_random_text();
        in_valid <= 1'b0;

        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
